// ===== hdl/pfc8_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet framer CRC-8 package
// Shared types, register map codes, frame constants and the CRC-8 step.
// ----------------------------------------------------------------------------
package pfc8_pkg;

    localparam logic [7:0] FRAME_SYNC    = 8'h55;
    localparam logic [7:0] FRAME_VERSION = 8'h01;
    localparam logic [7:0] NO_CRC_FILL   = 8'hAA;
    localparam logic [7:0] CRC8_POLY     = 8'h07;

    localparam int unsigned HEADER_LEN = 6;
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DATA_W     = 32;

    // Register indexes (byte address / 4).
    typedef enum logic [1:0] {
        REG_SOURCE_ADDRESS      = 2'd0,
        REG_DESTINATION_ADDRESS = 2'd1,
        REG_CRC_ENABLE          = 2'd2,
        REG_UNUSED              = 2'd3
    } reg_index_t;

    // Header byte positions within a frame.
    typedef enum logic [2:0] {
        HDR_SYNC    = 3'd0,
        HDR_VERSION = 3'd1,
        HDR_SOURCE  = 3'd2,
        HDR_DEST    = 3'd3,
        HDR_LENGTH  = 3'd4,
        HDR_FLAG    = 3'd5,
        HDR_NONE6   = 3'd6,
        HDR_NONE7   = 3'd7
    } hdr_pos_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] message_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    // One message byte folded into the CRC, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC8_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/packet_framer_crc8.sv =====
// ----------------------------------------------------------------------------
// Packet framer with CRC-8 check byte
// Wraps message bytes in a six byte header and closes each frame with a
// CRC-8 (poly 0x07) check byte, or 0xAA when the CRC is disabled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    pfc8_pkg::in_item_t  (one message byte)
//  m_        out        m_valid/m_ready    pfc8_pkg::out_item_t (one frame byte)
//  APB       in         psel/penable       source, destination, crc enable
//
// Each input transaction produces 1, 2, 7 or 8 output bytes, one per cycle
// when not stalled, holding the item register until its last byte loads;
// unstalled mid-packet bytes run at one transaction per cycle. The output
// register decouples the sides: a new transaction is taken in the cycle its
// predecessor's last byte loads. Reset (aresetn low, synchronous) empties both
// registers, closes any packet, restores source 0, destination 0, CRC enabled.
// ----------------------------------------------------------------------------
module packet_framer_crc8 (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  pfc8_pkg::in_item_t                s_payload,

    output logic                              m_valid,
    input  logic                              m_ready,
    output pfc8_pkg::out_item_t               m_payload,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfc8_pkg::ADDR_W-1:0]       paddr,
    input  logic [pfc8_pkg::DATA_W-1:0]       pwdata,
    output logic [pfc8_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    // Configuration registers
    logic [7:0] source_address_reg;
    logic [7:0] destination_address_reg;
    logic       crc_enable_reg;

    // Packet state
    logic [7:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0] crc_register_reg, crc_register_next;
    logic       packet_open_reg, packet_open_next;

    // Item register and byte sequencer
    logic                item_valid_reg, item_valid_next;
    pfc8_pkg::in_item_t  item_reg, item_next;
    logic [2:0]          step_reg, step_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    pfc8_pkg::out_item_t  m_payload_reg, m_payload_next;

    // Per-item decode
    logic       hdr;
    logic       len_zero;
    logic [7:0] rem_before;
    logic [7:0] rem_after;
    logic       is_check;
    logic [2:0] last_step;
    logic       at_last;
    logic       load;
    logic [7:0] crc_new;
    logic [7:0] check_byte;
    logic [7:0] cur_byte;
    logic       s_accept;
    logic       cfg_write;
    pfc8_pkg::reg_index_t reg_idx;

    assign reg_idx   = pfc8_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        case (reg_idx)
            pfc8_pkg::REG_SOURCE_ADDRESS:      prdata = {24'd0, source_address_reg};
            pfc8_pkg::REG_DESTINATION_ADDRESS: prdata = {24'd0, destination_address_reg};
            pfc8_pkg::REG_CRC_ENABLE:          prdata = {31'd0, crc_enable_reg};
            default:                           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_address_reg      <= 8'd0;
            destination_address_reg <= 8'd0;
            crc_enable_reg          <= 1'b1;
        end else if (cfg_write) begin
            case (reg_idx)
                pfc8_pkg::REG_SOURCE_ADDRESS:      source_address_reg      <= pwdata[7:0];
                pfc8_pkg::REG_DESTINATION_ADDRESS: destination_address_reg <= pwdata[7:0];
                pfc8_pkg::REG_CRC_ENABLE:          crc_enable_reg          <= pwdata[0];
                default: ;
            endcase
        end
    end

    // The packet state is committed only when the item's last byte loads,
    // so during emission it still reflects the start of the item.
    always_comb begin
        hdr        = !packet_open_reg;
        len_zero   = (item_reg.message_length == 8'd0);
        rem_before = hdr ? item_reg.message_length : bytes_remaining_reg;
        rem_after  = rem_before - 8'd1;
        crc_new    = pfc8_pkg::crc8_update(hdr ? 8'd0 : crc_register_reg, item_reg.data_byte);

        if (hdr && len_zero) begin
            is_check  = 1'b1;
            last_step = 3'(pfc8_pkg::HEADER_LEN);
        end else begin
            is_check  = (rem_after == 8'd0);
            last_step = (hdr ? 3'(pfc8_pkg::HEADER_LEN) : 3'd0) + {2'b00, is_check};
        end
        at_last = (step_reg == last_step);

        if (!crc_enable_reg) begin
            check_byte = pfc8_pkg::NO_CRC_FILL;
        end else if (hdr && len_zero) begin
            check_byte = 8'd0;
        end else begin
            check_byte = crc_new;
        end

        if (hdr && step_reg < 3'(pfc8_pkg::HEADER_LEN)) begin
            case (pfc8_pkg::hdr_pos_t'(step_reg))
                pfc8_pkg::HDR_SYNC:    cur_byte = pfc8_pkg::FRAME_SYNC;
                pfc8_pkg::HDR_VERSION: cur_byte = pfc8_pkg::FRAME_VERSION;
                pfc8_pkg::HDR_SOURCE:  cur_byte = source_address_reg;
                pfc8_pkg::HDR_DEST:    cur_byte = destination_address_reg;
                pfc8_pkg::HDR_LENGTH:  cur_byte = item_reg.message_length;
                pfc8_pkg::HDR_FLAG:    cur_byte = {7'd0, crc_enable_reg};
                default:               cur_byte = item_reg.data_byte;
            endcase
        end else if (at_last && is_check) begin
            cur_byte = check_byte;
        end else begin
            cur_byte = item_reg.data_byte;
        end
    end

    assign load     = item_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !item_valid_reg || (load && at_last);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        item_valid_next      = item_valid_reg;
        item_next            = item_reg;
        step_next            = step_reg;
        m_valid_next         = m_valid_reg;
        m_payload_next       = m_payload_reg;
        bytes_remaining_next = bytes_remaining_reg;
        crc_register_next    = crc_register_reg;
        packet_open_next     = packet_open_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            m_valid_next             = 1'b1;
            m_payload_next.out_byte  = cur_byte;
            m_payload_next.frame_end = at_last && is_check;
            m_payload_next.run_last  = at_last;
            if (at_last) begin
                step_next       = 3'd0;
                item_valid_next = 1'b0;
                if (hdr && len_zero) begin
                    crc_register_next    = 8'd0;
                    bytes_remaining_next = 8'd0;
                    packet_open_next     = 1'b0;
                end else begin
                    crc_register_next    = crc_new;
                    bytes_remaining_next = rem_after;
                    packet_open_next     = !is_check;
                end
            end else begin
                step_next = step_reg + 3'd1;
            end
        end

        if (s_accept) begin
            item_valid_next = 1'b1;
            item_next       = s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg      <= 1'b0;
            step_reg            <= 3'd0;
            m_valid_reg         <= 1'b0;
            bytes_remaining_reg <= 8'd0;
            crc_register_reg    <= 8'd0;
            packet_open_reg     <= 1'b0;
        end else begin
            item_valid_reg      <= item_valid_next;
            step_reg            <= step_next;
            m_valid_reg         <= m_valid_next;
            bytes_remaining_reg <= bytes_remaining_next;
            crc_register_reg    <= crc_register_next;
            packet_open_reg     <= packet_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    // A frame only ever closes on the last byte of a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_payload_reg.frame_end |-> m_payload_reg.run_last)
        else $error("frame_end without run_last");

    // An open packet always has message bytes still to come.
    assert property (@(posedge aclk) disable iff (!aresetn)
        packet_open_reg == (bytes_remaining_reg != 8'd0))
        else $error("packet_open and bytes_remaining disagree");

    // The sequencer only advances while a transaction is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 3'd0 |-> item_valid_reg)
        else $error("sequencer step without a held transaction");

    // Loading a check byte leaves no packet open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load && at_last && is_check |=> !packet_open_reg)
        else $error("packet still open after check byte");
`endif

endmodule
